/* rtl/array_doubly_linked_list_macros.svh */
// Assertion macros for the linked list block.
// Used by the modules that carry concurrent checks.
`ifndef ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH
`define ARRAY_DOUBLY_LINKED_LIST_MACROS_SVH

// implication check, disabled in reset
`define ADL_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication check, disabled in reset
`define ADL_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* rtl/adll_pkg.sv */
// Package for the array doubly linked list: sizes, beat types, action codes,
// controller states and the command struct. No dependencies.
package adll_pkg;

    localparam int NODES      = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ID_BITS    = $clog2(NODES);

    typedef logic [ID_BITS-1:0]    id_t;
    typedef logic [VALUE_BITS-1:0] val_t;

    typedef enum logic [2:0] {
        ACT_INS_HEAD   = 3'd0,
        ACT_INS_TAIL   = 3'd1,
        ACT_INS_AFTER  = 3'd2,
        ACT_INS_BEFORE = 3'd3,
        ACT_DELETE     = 3'd4,
        ACT_MOVE_HEAD  = 3'd5,
        ACT_MOVE_TAIL  = 3'd6,
        ACT_READ       = 3'd7
    } action_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [9:0]        node_id;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic [9:0]         new_id;
        logic [9:0]         head_id;
        logic [9:0]         tail_id;
        logic signed [31:0] read_value;
        logic [9:0]         read_prev;
        logic [9:0]         read_next;
        logic               rejected;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK,
        ST_CHECK,
        ST_LINK0,
        ST_LINK1,
        ST_APPLY,
        ST_FETCH,
        ST_RESULT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;   // latch request beat
        logic look;      // read ref node links and live bit
        logic check;     // register links, decide reject
        logic link0;     // first link write step
        logic link1;     // second link write step
        logic apply;     // last link write, register updates
        logic fetch;     // read chosen node
        logic result;    // load output register
    } cmd_t;

endpackage

/* rtl/array_doubly_linked_list.sv */
// Top level of the array doubly linked list: controller plus datapath.
// Depends on adll_pkg, adll_ctrl and adll_dp.
//   channel   direction  handshake             payload
//   request   in         in_valid/in_ready     req  (adll_pkg::req_t)
//   response  out        out_valid/out_ready   rsp  (adll_pkg::rsp_t)
// Response valid follows the request beat through look, check, three
// link write steps (one prev and one next entry each), fetch and result.
// Next request is accepted the cycle after the response is loaded; one request is in flight at a time.
// Reset clears head and tail and sets the id counter to 1; ids at or above it read as dead.
// A stalled response holds its register; a following request waits in result.
module array_doubly_linked_list (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  adll_pkg::req_t    req,
    output logic              out_valid,
    input  logic              out_ready,
    output adll_pkg::rsp_t    rsp
);
    import adll_pkg::*;

    cmd_t cmd;

    adll_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    adll_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );
endmodule

/* rtl/adll_ctrl.sv */
// Controller for the linked list: one request at a time through look, check,
// three link write steps, fetch and result. Uses adll_pkg.
`include "array_doubly_linked_list_macros.svh"
module adll_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output adll_pkg::cmd_t  cmd
);
    import adll_pkg::*;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_valid) state_next = ST_LOOK;
            ST_LOOK:   state_next = ST_CHECK;
            ST_CHECK:  state_next = ST_LINK0;
            ST_LINK0:  state_next = ST_LINK1;
            ST_LINK1:  state_next = ST_APPLY;
            ST_APPLY:  state_next = ST_FETCH;
            ST_FETCH:  state_next = ST_RESULT;
            ST_RESULT: if (!out_valid_reg || out_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
            end
            ST_LOOK:  cmd.look = 1'b1;
            ST_CHECK: cmd.check = 1'b1;
            ST_LINK0: cmd.link0 = 1'b1;
            ST_LINK1: cmd.link1 = 1'b1;
            ST_APPLY: cmd.apply = 1'b1;
            ST_FETCH: cmd.fetch = 1'b1;
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;

    `ADL_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, state_reg == ST_IDLE)
    `ADL_ASSERT_NXT(a_result_valid, clk, rst_n, cmd.result, out_valid_reg)
    `ADL_ASSERT_NXT(a_hold, clk, rst_n, out_valid_reg && !out_ready && !cmd.result,
        out_valid_reg)
endmodule

/* rtl/adll_dp.sv */
// Datapath for the linked list: link, value and live memories, head/tail
// and id registers, the link write plan and the result register. Uses adll_pkg.
`include "array_doubly_linked_list_macros.svh"
module adll_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  adll_pkg::cmd_t  cmd,
    input  adll_pkg::req_t  req,
    output adll_pkg::rsp_t  rsp
);
    import adll_pkg::*;

    // memories are not reset; ids at or above the free counter count as dead
    id_t   prev_mem [NODES];
    id_t   next_mem [NODES];
    val_t  val_mem  [NODES];
    logic  live_mem [NODES];

    id_t   head_reg, tail_reg;
    logic  [ID_BITS:0] free_reg;

    logic [2:0] act_reg;
    id_t   k_reg;
    val_t  v_reg;
    logic  kval_reg;   // node_id fits and is nonzero
    id_t   kp_rd, kn_rd; // registered link reads of k
    logic  live_rd;
    id_t   kp_reg, kn_reg;
    logic  live_k_reg;
    logic  rej_reg;
    id_t   nid_reg, ch_reg;
    id_t   cp_rd, cn_rd;
    val_t  cv_rd;

    logic ins, ok, live_k, lnk;
    id_t  nid;
    logic pw_en, nw_en, lw_en, lw_data;
    id_t  pw_addr, pw_data, nw_addr, nw_data, lw_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg  <= req.action;
            k_reg    <= id_t'(req.node_id);
            kval_reg <= (req.node_id != '0) && ({22'd0, req.node_id} < 32'(NODES));
            v_reg    <= val_t'(req.value);
        end
        if (cmd.look)
        begin
            kp_rd   <= prev_mem[k_reg];
            kn_rd   <= next_mem[k_reg];
            live_rd <= live_mem[k_reg];
        end
        if (cmd.fetch)
        begin
            cp_rd <= prev_mem[ch_reg];
            cn_rd <= next_mem[ch_reg];
            cv_rd <= val_mem[ch_reg];
        end
    end

    always_comb
    begin
        ins    = (act_reg <= ACT_INS_BEFORE);
        ok     = !rej_reg;
        nid    = id_t'(free_reg);
        live_k = kval_reg && ({1'b0, k_reg} < free_reg) && live_rd;
        // a move of a node already at that end changes nothing
        lnk    = ok && !((act_reg == ACT_MOVE_HEAD) && (head_reg == k_reg)) &&
                 !((act_reg == ACT_MOVE_TAIL) && (tail_reg == k_reg));
    end

    // link writes: at most one prev and one next entry per step
    always_comb
    begin
        pw_en = 1'b0; pw_addr = '0; pw_data = '0;
        nw_en = 1'b0; nw_addr = '0; nw_data = '0;
        if (lnk && cmd.link0)
        begin
            case (act_reg)
                ACT_INS_HEAD:
                begin
                    pw_en = 1'b1; pw_addr = nid; pw_data = '0;
                    nw_en = 1'b1; nw_addr = nid; nw_data = head_reg;
                end
                ACT_INS_TAIL:
                begin
                    pw_en = 1'b1; pw_addr = nid; pw_data = tail_reg;
                    nw_en = 1'b1; nw_addr = nid; nw_data = '0;
                end
                ACT_INS_AFTER:
                begin
                    pw_en = 1'b1; pw_addr = nid; pw_data = k_reg;
                    nw_en = 1'b1; nw_addr = nid; nw_data = kn_reg;
                end
                ACT_INS_BEFORE:
                begin
                    pw_en = 1'b1; pw_addr = nid; pw_data = kp_reg;
                    nw_en = 1'b1; nw_addr = nid; nw_data = k_reg;
                end
                ACT_DELETE, ACT_MOVE_HEAD, ACT_MOVE_TAIL:
                begin
                    // unlink k from its neighbors
                    pw_en = (kn_reg != '0); pw_addr = kn_reg; pw_data = kp_reg;
                    nw_en = (kp_reg != '0); nw_addr = kp_reg; nw_data = kn_reg;
                end
                default: ;
            endcase
        end
        else if (lnk && cmd.link1)
        begin
            case (act_reg)
                ACT_INS_HEAD:
                begin
                    pw_en = (head_reg != '0); pw_addr = head_reg; pw_data = nid;
                end
                ACT_INS_TAIL:
                begin
                    nw_en = (tail_reg != '0); nw_addr = tail_reg; nw_data = nid;
                end
                ACT_INS_AFTER:
                begin
                    pw_en = (kn_reg != '0); pw_addr = kn_reg; pw_data = nid;
                    nw_en = 1'b1; nw_addr = k_reg; nw_data = nid;
                end
                ACT_INS_BEFORE:
                begin
                    nw_en = (kp_reg != '0); nw_addr = kp_reg; nw_data = nid;
                    pw_en = 1'b1; pw_addr = k_reg; pw_data = nid;
                end
                ACT_MOVE_HEAD:
                begin
                    pw_en = 1'b1; pw_addr = head_reg; pw_data = k_reg;
                    nw_en = 1'b1; nw_addr = k_reg; nw_data = head_reg;
                end
                ACT_MOVE_TAIL:
                begin
                    nw_en = 1'b1; nw_addr = tail_reg; nw_data = k_reg;
                    pw_en = 1'b1; pw_addr = k_reg; pw_data = tail_reg;
                end
                default: ;
            endcase
        end
        else if (lnk && cmd.apply)
        begin
            case (act_reg)
                ACT_MOVE_HEAD:
                begin
                    pw_en = 1'b1; pw_addr = k_reg; pw_data = '0;
                end
                ACT_MOVE_TAIL:
                begin
                    nw_en = 1'b1; nw_addr = k_reg; nw_data = '0;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        lw_en   = ok && cmd.apply && (ins || (act_reg == ACT_DELETE));
        lw_addr = ins ? nid : k_reg;
        lw_data = ins;
    end

    always_ff @(posedge clk)
    begin
        if (pw_en) prev_mem[pw_addr] <= pw_data;
        if (nw_en) next_mem[nw_addr] <= nw_data;
        if (lw_en) live_mem[lw_addr] <= lw_data;
        if (cmd.apply && ok && ins) val_mem[nid] <= v_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            free_reg <= (ID_BITS+1)'(1);
            rej_reg  <= 1'b0;
            nid_reg  <= '0;
            ch_reg   <= '0;
            kp_reg   <= '0;
            kn_reg   <= '0;
            live_k_reg <= 1'b0;
        end
        else
        begin
            if (cmd.check)
            begin
                kp_reg <= kp_rd;
                kn_reg <= kn_rd;
                live_k_reg <= live_k;
                rej_reg <= ((act_reg <= ACT_INS_BEFORE) &&
                            (free_reg >= (ID_BITS+1)'(NODES))) ||
                           ((act_reg >= ACT_INS_AFTER) && !live_k);
            end
            if (cmd.apply)
            begin
                nid_reg <= (ok && ins) ? nid : '0;
                ch_reg  <= !ok ? '0 : ins ? nid : (act_reg == ACT_DELETE) ? '0 : k_reg;
                if (ok)
                begin
                    if (ins)
                    begin
                        free_reg <= free_reg + 1'b1;
                    end
                    case (act_reg)
                        ACT_INS_HEAD:
                        begin
                            head_reg <= nid;
                            if (tail_reg == '0) tail_reg <= nid;
                        end
                        ACT_INS_TAIL:
                        begin
                            tail_reg <= nid;
                            if (head_reg == '0) head_reg <= nid;
                        end
                        ACT_INS_AFTER:  if (tail_reg == k_reg) tail_reg <= nid;
                        ACT_INS_BEFORE: if (head_reg == k_reg) head_reg <= nid;
                        ACT_DELETE:
                        begin
                            if (head_reg == k_reg) head_reg <= kn_reg;
                            if (tail_reg == k_reg) tail_reg <= kp_reg;
                        end
                        ACT_MOVE_HEAD:
                        begin
                            head_reg <= k_reg;
                            if (tail_reg == k_reg && kp_reg != '0) tail_reg <= kp_reg;
                        end
                        ACT_MOVE_TAIL:
                        begin
                            tail_reg <= k_reg;
                            if (head_reg == k_reg && kn_reg != '0) head_reg <= kn_reg;
                        end
                        default: ;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result)
        begin
            rsp.new_id     <= 10'(nid_reg);
            rsp.head_id    <= 10'(head_reg);
            rsp.tail_id    <= 10'(tail_reg);
            rsp.read_value <= (ch_reg != '0) ? 32'(cv_rd) : '0;
            rsp.read_prev  <= (ch_reg != '0) ? 10'(cp_rd) : '0;
            rsp.read_next  <= (ch_reg != '0) ? 10'(cn_rd) : '0;
            rsp.rejected   <= rej_reg;
        end
    end

    `ADL_ASSERT_IMP(a_head_tail, clk, rst_n, cmd.result, (head_reg == '0) == (tail_reg == '0))
    `ADL_ASSERT_NXT(a_rej_hold, clk, rst_n, cmd.apply && rej_reg,
        (free_reg == $past(free_reg)) && (head_reg == $past(head_reg)))
    `ADL_ASSERT_NXT(a_free_rise, clk, rst_n, cmd.apply && ok && ins,
        free_reg == $past(free_reg) + 1'b1)
    `ADL_ASSERT_IMP(a_live_k, clk, rst_n, cmd.apply && ok && !ins, live_k_reg)
    `ADL_ASSERT_IMP(a_wr_addr, clk, rst_n, pw_en || nw_en,
        (!pw_en || pw_addr != '0) && (!nw_en || nw_addr != '0))
endmodule

/* verif/tb.sv */
// Testbench for array_doubly_linked_list: directed table then random requests,
// every response checked against a behavioral list kept here. Depends on adll_pkg.
module tb;
    import adll_pkg::*;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    req_t req;
    logic out_valid;
    logic out_ready;
    rsp_t rsp;

    array_doubly_linked_list i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req       (req),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // behavioral list state
    id_t  lst_prev [NODES];
    id_t  lst_next [NODES];
    val_t lst_val  [NODES];
    bit   lst_live [NODES];
    id_t  lst_head;
    id_t  lst_tail;
    int   lst_free;

    rsp_t pending_rsp [$];
    int   err_cnt;
    bit   calm;  // no idling in the final stretch

    typedef struct {
        action_t act;
        int      nid;
        int      val;
        bit      has_exp;
        rsp_t    exp;
    } dir_row_t;

    dir_row_t dir_tab [$];

    function automatic void list_unlink(id_t k);
        id_t p;
        id_t n;
        p = lst_prev[k];
        n = lst_next[k];
        if (p != 0) lst_next[p] = n;
        if (n != 0) lst_prev[n] = p;
        if (lst_head == k) lst_head = n;
        if (lst_tail == k) lst_tail = p;
    endfunction

    function automatic void list_put_head(id_t k);
        lst_next[k] = lst_head;
        lst_prev[k] = '0;
        if (lst_head != 0) lst_prev[lst_head] = k;
        lst_head = k;
        if (lst_tail == 0) lst_tail = k;
    endfunction

    function automatic void list_put_tail(id_t k);
        lst_prev[k] = lst_tail;
        lst_next[k] = '0;
        if (lst_tail != 0) lst_next[lst_tail] = k;
        lst_tail = k;
        if (lst_head == 0) lst_head = k;
    endfunction

    function automatic rsp_t list_apply(req_t r);
        rsp_t o;
        action_t a;
        id_t k;
        id_t nid;
        id_t sel;
        bit ins;
        bit ok;
        bit rej;
        a = action_t'(r.action);
        ins = (a <= ACT_INS_BEFORE);
        ok = (r.node_id != 0) && lst_live[r.node_id];
        k = ok ? id_t'(r.node_id) : id_t'(0);
        rej = (ins && lst_free >= NODES) || (a >= ACT_INS_AFTER && !ok);
        nid = '0;
        sel = '0;
        if (!rej) begin
            if (ins) begin
                nid = id_t'(lst_free);
                lst_free++;
                lst_val[nid] = r.value;
                lst_live[nid] = 1'b1;
                sel = nid;
            end
            case (a)
                ACT_INS_HEAD: list_put_head(nid);
                ACT_INS_TAIL: list_put_tail(nid);
                ACT_INS_AFTER:
                begin
                    lst_next[nid] = lst_next[k];
                    lst_prev[nid] = k;
                    if (lst_next[k] != 0) lst_prev[lst_next[k]] = nid;
                    lst_next[k] = nid;
                    if (lst_tail == k) lst_tail = nid;
                end
                ACT_INS_BEFORE:
                begin
                    lst_prev[nid] = lst_prev[k];
                    lst_next[nid] = k;
                    if (lst_prev[k] != 0) lst_next[lst_prev[k]] = nid;
                    lst_prev[k] = nid;
                    if (lst_head == k) lst_head = nid;
                end
                ACT_DELETE:
                begin
                    list_unlink(k);
                    lst_live[k] = 1'b0;
                end
                ACT_MOVE_HEAD:
                begin
                    list_unlink(k);
                    list_put_head(k);
                    sel = k;
                end
                ACT_MOVE_TAIL:
                begin
                    list_unlink(k);
                    list_put_tail(k);
                    sel = k;
                end
                default: sel = k;
            endcase
        end
        o.new_id = nid;
        o.head_id = lst_head;
        o.tail_id = lst_tail;
        o.read_value = (sel != 0) ? lst_val[sel] : '0;
        o.read_prev = (sel != 0) ? lst_prev[sel] : '0;
        o.read_next = (sel != 0) ? lst_next[sel] : '0;
        o.rejected = rej;
        return o;
    endfunction

    // pick a live id most of the time so the deep paths get exercised
    function automatic int pick_node();
        int tries;
        int c;
        if ($urandom_range(9) == 0) return $urandom_range(1023);
        for (tries = 0; tries < 30; tries++) begin
            c = $urandom_range(1, (lst_free > 1) ? lst_free - 1 : 1);
            if (lst_live[c]) return c;
        end
        return lst_head;
    endfunction

    task automatic send_beat(action_t a, int nid, int v, bit has_exp, rsp_t e);
        req_t r;
        rsp_t p;
        int gap;
        if (!calm && $urandom_range(3) == 0) begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        r.action = a;
        r.node_id = nid[9:0];
        r.value = v;
        req <= r;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        p = list_apply(r);
        if (has_exp && p != e) begin
            $display("%0t directed row: expected %h predictor %h", $time, e, p);
            err_cnt++;
        end
        pending_rsp.push_back(p);
    endtask

    function automatic rsp_t mk_rsp(int n, int h, int t, int v, int p, int x, bit rj);
        rsp_t o;
        o = '{new_id: n[9:0], head_id: h[9:0], tail_id: t[9:0], read_value: v,
              read_prev: p[9:0], read_next: x[9:0], rejected: rj};
        return o;
    endfunction

    // response side: random backpressure, compare against oldest expectation
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready) begin
                if (pending_rsp.size() == 0) begin
                    $display("%0t unexpected response %h", $time, rsp);
                    err_cnt++;
                end
                else begin
                    rsp_t e;
                    e = pending_rsp.pop_front();
                    if (rsp.new_id !== e.new_id || rsp.head_id !== e.head_id ||
                        rsp.tail_id !== e.tail_id || rsp.read_value !== e.read_value ||
                        rsp.read_prev !== e.read_prev || rsp.read_next !== e.read_next ||
                        rsp.rejected !== e.rejected) begin
                        $display("%0t mismatch: expected %h actual %h", $time, e, rsp);
                        err_cnt++;
                    end
                end
            end
            if (!calm && $urandom_range(4) == 0) begin
                gap = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
                out_ready <= 1'b1;
            end
            else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        int i;
        int a;
        rsp_t none;
        none = '0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req = '0;
        err_cnt = 0;
        calm = 1'b0;
        lst_head = '0;
        lst_tail = '0;
        lst_free = 1;
        for (i = 0; i < NODES; i++) lst_live[i] = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows; empty list cases have obvious results
        dir_tab.push_back('{ACT_READ, 1, 0, 1, mk_rsp(0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ACT_DELETE, 0, 0, 1, mk_rsp(0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ACT_INS_AFTER, 5, 0, 1, mk_rsp(0, 0, 0, 0, 0, 0, 1)});
        dir_tab.push_back('{ACT_INS_TAIL, 0, 32'h7fffffff, 1,
                            mk_rsp(1, 1, 1, 32'h7fffffff, 0, 0, 0)});
        dir_tab.push_back('{ACT_INS_HEAD, 1023, 32'h80000000, 1,
                            mk_rsp(2, 2, 1, 32'h80000000, 0, 1, 0)});
        dir_tab.push_back('{ACT_INS_AFTER, 2, -1, 1, mk_rsp(3, 2, 1, -1, 2, 1, 0)});
        dir_tab.push_back('{ACT_INS_BEFORE, 2, 0, 0, none});
        dir_tab.push_back('{ACT_INS_AFTER, 1, 12345, 0, none});
        dir_tab.push_back('{ACT_MOVE_HEAD, 1, 0, 0, none});
        dir_tab.push_back('{ACT_MOVE_TAIL, 4, 0, 0, none});
        dir_tab.push_back('{ACT_MOVE_HEAD, 4, 0, 0, none});
        dir_tab.push_back('{ACT_DELETE, 3, 0, 0, none});
        dir_tab.push_back('{ACT_READ, 3, 0, 0, none});
        // list is 4,1,2,5 here; a dead id is refused
        dir_tab.push_back('{ACT_MOVE_TAIL, 1023, 0, 1, mk_rsp(0, 4, 5, 0, 0, 0, 1)});
        dir_tab.push_back('{ACT_READ, 1023, 0, 0, none});
        dir_tab.push_back('{ACT_READ, 5, 0, 0, none});
        dir_tab.push_back('{ACT_INS_BEFORE, 0, 0, 0, none});
        dir_tab.push_back('{ACT_DELETE, 2, 0, 0, none});
        for (i = 0; i < dir_tab.size(); i++) begin
            if (dir_tab[i].has_exp && dir_tab[i].exp == none) begin
                dir_tab[i].exp.rejected = 1'b1;
            end
            send_beat(dir_tab[i].act, dir_tab[i].nid, dir_tab[i].val,
                      dir_tab[i].has_exp, dir_tab[i].exp);
        end

        // random mix of all actions, mostly on live ids
        for (i = 0; i < 380; i++) begin
            if (i > 330) calm = 1'b1;
            a = $urandom_range(7);
            if (lst_head == 0 && $urandom_range(1) == 0) a = ACT_INS_TAIL;
            send_beat(action_t'(a), (a <= ACT_INS_TAIL) ? $urandom_range(1023) : pick_node(),
                      $urandom(), 1'b0, none);
        end
        in_valid <= 1'b0;

        while (pending_rsp.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (err_cnt == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+rtl
rtl/adll_pkg.sv
rtl/adll_ctrl.sv
rtl/adll_dp.sv
rtl/array_doubly_linked_list.sv
verif/tb.sv
